/* src/lbps_pkg.sv */
// ----------------------------------------------------------------------------
// Light bar sequencer package
// Shared widths, program and register codes, phase tables.
// ----------------------------------------------------------------------------
package lbps_pkg;

  localparam int unsigned DutyW     = 13;
  localparam int unsigned CheckW    = 4;
  localparam int unsigned ProgW     = 3;
  localparam int unsigned LevelW    = 2;
  localparam int unsigned PhaseW    = 4;
  localparam int unsigned TicksW    = 9;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned NumLevels = 4;

  typedef logic [DutyW-1:0]   duty_t;
  typedef logic [CheckW-1:0]  check_t;
  typedef logic [ProgW-1:0]   prog_t;
  typedef logic [LevelW-1:0]  level_t;
  typedef logic [PhaseW-1:0]  phase_t;
  typedef logic [TicksW-1:0]  ticks_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  typedef struct packed {
    logic left;
    logic strobe;
    logic right;
  } lamp_t;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  // program codes
  localparam prog_t PROG_OFF         = 3'd0;
  localparam prog_t PROG_ON          = 3'd1;
  localparam prog_t PROG_LEFT        = 3'd2;
  localparam prog_t PROG_RIGHT       = 3'd3;
  localparam prog_t PROG_BLINK       = 3'd4;
  localparam prog_t PROG_BLINK_LEFT  = 3'd5;
  localparam prog_t PROG_BLINK_RIGHT = 3'd6;

  // register indexes
  localparam cfg_idx_t CFG_DUTY_ZERO        = 3'd0;
  localparam cfg_idx_t CFG_DUTY_ONE         = 3'd1;
  localparam cfg_idx_t CFG_DUTY_TWO         = 3'd2;
  localparam cfg_idx_t CFG_DUTY_THREE       = 3'd3;
  localparam cfg_idx_t CFG_CYCLES_PER_CHECK = 3'd4;

  // register reset values
  localparam duty_t  DUTY_ZERO_RST  = 13'd744;
  localparam duty_t  DUTY_ONE_RST   = 13'd2023;
  localparam duty_t  DUTY_TWO_RST   = 13'd4221;
  localparam duty_t  DUTY_THREE_RST = 13'd7999;
  localparam check_t CHECK_RST      = 4'd6;

  localparam ticks_t STEADY_LEN       = 9'd301;
  localparam phase_t BLINK_LAST_PHASE = 4'd9;
  localparam phase_t STEADY_LAST      = 4'd0;

  function automatic logic is_blink(prog_t prog);
    return (prog == PROG_BLINK) || (prog == PROG_BLINK_LEFT) || (prog == PROG_BLINK_RIGHT);
  endfunction

  function automatic logic is_running(prog_t prog);
    return (prog != PROG_OFF) && (prog <= PROG_BLINK_RIGHT);
  endfunction

  // ticks in the current phase
  function automatic ticks_t phase_length(prog_t prog, phase_t idx);
    ticks_t len;
    len = STEADY_LEN;
    if (is_blink(prog)) begin
      case (idx)
        4'd0, 4'd2:               len = 9'd41;
        4'd4, 4'd5, 4'd6, 4'd7,
        4'd8:                     len = 9'd9;
        default:                  len = 9'd61;
      endcase
    end
    return len;
  endfunction

  // lit lamps for a program and phase
  function automatic lamp_t phase_mask(prog_t prog, phase_t idx);
    lamp_t side;
    lamp_t mask;
    side = '0;
    mask = '0;
    case (prog)
      PROG_ON:          mask = '{left: 1'b1, strobe: 1'b0, right: 1'b1};
      PROG_LEFT:        mask = '{left: 1'b1, strobe: 1'b0, right: 1'b0};
      PROG_RIGHT:       mask = '{left: 1'b0, strobe: 1'b0, right: 1'b1};
      PROG_BLINK:       side = '{left: 1'b1, strobe: 1'b0, right: 1'b1};
      PROG_BLINK_LEFT:  side = '{left: 1'b1, strobe: 1'b0, right: 1'b0};
      PROG_BLINK_RIGHT: side = '{left: 1'b0, strobe: 1'b0, right: 1'b1};
      default:          mask = '0;
    endcase
    if (is_blink(prog)) begin
      case (idx)
        4'd0, 4'd2:       mask = side;
        4'd4, 4'd6, 4'd8: mask = '{left: side.left, strobe: 1'b1, right: side.right};
        default:          mask = '0;
      endcase
    end
    return mask;
  endfunction

endpackage

/* src/lbps_in_if.sv */
// ----------------------------------------------------------------------------
// Light bar sequencer input channel
// Valid/ready channel carrying one tick or command beat.
// ----------------------------------------------------------------------------
interface lbps_in_if;
  logic                   valid;
  logic                   ready;
  logic                   operation;
  lbps_pkg::prog_t        program_req;
  lbps_pkg::level_t       brightness_level;

  modport source (output valid, operation, program_req, brightness_level, input ready);
  modport sink   (input valid, operation, program_req, brightness_level, output ready);
endinterface

/* src/lbps_out_if.sv */
// ----------------------------------------------------------------------------
// Light bar sequencer result channel
// Valid/ready channel carrying three duty values and the dark flag.
// ----------------------------------------------------------------------------
interface lbps_out_if;
  logic                valid;
  logic                ready;
  lbps_pkg::duty_t     left_duty;
  lbps_pkg::duty_t     strobe_duty;
  lbps_pkg::duty_t     right_duty;
  logic                is_dark;

  modport source (output valid, left_duty, strobe_duty, right_duty, is_dark, input ready);
  modport sink   (input valid, left_duty, strobe_duty, right_duty, is_dark, output ready);
endinterface

/* src/light_bar_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// Light bar pattern sequencer
// Steps a warning light bar through its phase tables, one beat per tick or
// command, and returns the left, strobe and right PWM compare values.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  --------  ---  ------------------  -----------------------------------------
//  in_i      in   valid/ready         operation, program_req, brightness_level
//  out_o     out  valid/ready         left_duty, strobe_duty, right_duty, is_dark
//  cfg       in   cfg_we_i (no wait)  cfg_idx_i, cfg_data_i
//
//  Pipeline: two register stages (input beat register, result register); a beat
//  accepted on in_i passes through the input register, then the result register
//  to out_o, and one beat is taken every cycle while out_o is ready.
//  Sequencer state advances in the cycle the beat leaves the input register.
//  Reset: duty and check registers take their defaults, program off, all
//  counters zero, both stages empty.
//  Stalls: out_o.ready low holds the result register; the input register
//  still fills, then in_i.ready drops until the result moves on.
//
module light_bar_pattern_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  lbps_in_if.sink             in_i,
  lbps_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  lbps_pkg::cfg_idx_t  cfg_idx_i,
  input  lbps_pkg::duty_t     cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  lbps_pkg::duty_t  duty_q [lbps_pkg::NumLevels];
  lbps_pkg::check_t check_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q[0] <= lbps_pkg::DUTY_ZERO_RST;
      duty_q[1] <= lbps_pkg::DUTY_ONE_RST;
      duty_q[2] <= lbps_pkg::DUTY_TWO_RST;
      duty_q[3] <= lbps_pkg::DUTY_THREE_RST;
      check_q   <= lbps_pkg::CHECK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lbps_pkg::CFG_DUTY_ZERO:        duty_q[0] <= cfg_data_i;
        lbps_pkg::CFG_DUTY_ONE:         duty_q[1] <= cfg_data_i;
        lbps_pkg::CFG_DUTY_TWO:         duty_q[2] <= cfg_data_i;
        lbps_pkg::CFG_DUTY_THREE:       duty_q[3] <= cfg_data_i;
        lbps_pkg::CFG_CYCLES_PER_CHECK: check_q   <= cfg_data_i[lbps_pkg::CheckW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input beat register
  // --------------------------------------------------------------------------
  logic               s1_valid_q;
  logic               s1_op_q;
  lbps_pkg::prog_t    s1_prog_q;
  lbps_pkg::level_t   s1_level_q;

  logic advance;   // result register can take a new beat
  logic fire;      // beat in the input register is processed now

  assign advance    = !out_o.valid || out_o.ready;
  assign fire       = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_op_q    <= in_i.operation;
      s1_prog_q  <= in_i.program_req;
      s1_level_q <= in_i.brightness_level;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  lbps_pkg::prog_t  prog_q, prog_d;
  lbps_pkg::level_t level_q, level_d;
  lbps_pkg::phase_t idx_q, idx_d;
  lbps_pkg::ticks_t ticks_q, ticks_d;
  lbps_pkg::check_t cc_q, cc_d;
  logic             seen_q, seen_d;
  logic             dark_q, dark_d;

  // what the result shows: state after a command, state before a tick
  lbps_pkg::prog_t  view_prog;
  lbps_pkg::level_t view_level;
  lbps_pkg::phase_t view_idx;
  logic             view_dark;

  lbps_pkg::ticks_t ticks_inc;
  lbps_pkg::check_t cc_inc;
  lbps_pkg::check_t limit;
  lbps_pkg::phase_t last_idx;

  assign ticks_inc = ticks_q + lbps_pkg::ticks_t'(1);
  assign cc_inc    = cc_q + lbps_pkg::check_t'(1);   // wraps at 4 bits
  assign limit     = (check_q == '0) ? lbps_pkg::check_t'(1) : check_q;
  assign last_idx  = lbps_pkg::is_blink(prog_q) ? lbps_pkg::BLINK_LAST_PHASE
                                                : lbps_pkg::STEADY_LAST;

  always_comb begin
    prog_d  = prog_q;
    level_d = level_q;
    idx_d   = idx_q;
    ticks_d = ticks_q;
    cc_d    = cc_q;
    seen_d  = seen_q;
    dark_d  = dark_q;

    if (s1_op_q == lbps_pkg::OP_CMD) begin
      seen_d = 1'b1;
      dark_d = 1'b0;
      // a changed program or level restarts the pattern
      if (s1_prog_q != prog_q || s1_level_q != level_q) begin
        prog_d  = s1_prog_q;
        level_d = s1_level_q;
        idx_d   = '0;
        ticks_d = '0;
        cc_d    = '0;
      end
      view_prog  = prog_d;
      view_level = level_d;
      view_idx   = idx_d;
      view_dark  = 1'b0;
    end else begin
      view_prog  = prog_q;
      view_level = level_q;
      view_idx   = idx_q;
      view_dark  = dark_q;
      // frozen while dark, off or on the unused program code
      if (!dark_q && lbps_pkg::is_running(prog_q)) begin
        if (ticks_inc >= lbps_pkg::phase_length(prog_q, idx_q)) begin
          ticks_d = '0;
          if (idx_q == last_idx) begin
            // pattern cycle complete
            idx_d = '0;
            if (cc_inc >= limit) begin
              cc_d = '0;
              if (seen_q) begin
                seen_d = 1'b0;
              end else begin
                dark_d = 1'b1;
              end
            end else begin
              cc_d = cc_inc;
            end
          end else begin
            idx_d = idx_q + lbps_pkg::phase_t'(1);
          end
        end else begin
          ticks_d = ticks_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q  <= lbps_pkg::PROG_OFF;
      level_q <= '0;
      idx_q   <= '0;
      ticks_q <= '0;
      cc_q    <= '0;
      seen_q  <= 1'b0;
      dark_q  <= 1'b0;
    end else if (fire) begin
      prog_q  <= prog_d;
      level_q <= level_d;
      idx_q   <= idx_d;
      ticks_q <= ticks_d;
      cc_q    <= cc_d;
      seen_q  <= seen_d;
      dark_q  <= dark_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  lbps_pkg::lamp_t mask;
  lbps_pkg::duty_t duty;

  assign mask = view_dark ? '0 : lbps_pkg::phase_mask(view_prog, view_idx);
  assign duty = duty_q[view_level];

  logic            out_valid_q;
  lbps_pkg::duty_t left_q, strobe_q, right_q;
  logic            is_dark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      left_q    <= mask.left   ? duty : '0;
      strobe_q  <= mask.strobe ? duty : '0;
      right_q   <= mask.right  ? duty : '0;
      is_dark_q <= view_dark;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.left_duty   = left_q;
  assign out_o.strobe_duty = strobe_q;
  assign out_o.right_duty  = right_q;
  assign out_o.is_dark     = is_dark_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_dark_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dark_q |-> lbps_pkg::is_running(prog_q))
    else $error("dark hold with no running program");

  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q <= lbps_pkg::BLINK_LAST_PHASE) &&
    (lbps_pkg::is_blink(prog_q) || idx_q == lbps_pkg::STEADY_LAST))
    else $error("phase index out of range for program");

  a_ticks_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ticks_q < lbps_pkg::phase_length(prog_q, idx_q))
    else $error("tick count past phase length");

  a_dark_result_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && is_dark_q) |-> (left_q == '0 && strobe_q == '0 && right_q == '0))
    else $error("lamp lit while held dark");

  a_cmd_clears_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_op_q == lbps_pkg::OP_CMD) |=> (!dark_q && seen_q))
    else $error("command beat did not clear dark hold");

endmodule
